[rtl/aloa_pkg.sv]
// ----------------------------------------------------------------------------
// aloa_pkg
// Shared constants, register codes and controller/datapath bundles for the
// loop recorder with overdub and automatic gain reduction.
// ----------------------------------------------------------------------------
package aloa_pkg;

   // loop store geometry
   localparam int LOOP_DEPTH = 32768;
   localparam int ADDR_W     = $clog2(LOOP_DEPTH);
   // width for comparing position+1 against the programmed length
   localparam int CMP_W      = (ADDR_W + 1 > 16) ? ADDR_W + 1 : 16;

   // sample and gain encodings
   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
   localparam logic [16:0]        GAIN_UNITY = 17'h10000;

   // configuration reset values
   localparam logic [15:0] LOOP_LENGTH_RESET = 16'd20000;
   localparam logic [15:0] CLIP_LIMIT_RESET  = 16'd3000;

   // serial divider for the gain: one quotient bit per step
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_LOOP_LENGTH = 1'b0;
   localparam logic REG_CLIP_LIMIT  = 1'b1;

   typedef struct packed {
      logic accept;     // capture sample, update input extremes, form difference
      logic mul;        // register gain product
      logic store;      // saturate, mix into store, pass-end bookkeeping
      logic eval;       // compare range against clip limit, set up divider
      logic div_step;   // one restoring divide step
      logic gain_load;  // quotient becomes the new gain
      logic out_load;   // result into the output register
   } aloa_cmd_type;

   typedef struct packed {
      logic pass_end;   // valid during the store step
      logic clip;       // valid during the eval step
   } aloa_stat_type;

endpackage

[rtl/aloa_ram.sv]
// ----------------------------------------------------------------------------
// aloa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aloa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/aloa_ctrl.sv]
// ----------------------------------------------------------------------------
// aloa_ctrl
// Sequencer: walks one sample through scale, store and pass-end gain update,
// and owns the input ready and output valid handshake.
// ----------------------------------------------------------------------------
module aloa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output aloa_pkg::aloa_cmd_type cmd,
   input  aloa_pkg::aloa_stat_type stat
);
   import aloa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_STORE,
      ST_EVAL,
      ST_DIV,
      ST_GAIN,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic                   out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = stat.pass_end ? ST_EVAL : ST_FINISH;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            cnt_in   = '0;
            state_in = stat.clip ? ST_DIV : ST_FINISH;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_GAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_GAIN: begin
            cmd.gain_load = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load  = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // a new result only appears out of the finish step
   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result valid raised outside finish step");

   // step counter only runs while dividing
   a_cnt_in_div: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (state_ff == ST_DIV))
      else $error("divide counter active outside divide");

   // gain is loaded only after the full set of divide steps
   a_gain_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAIN) |->
         $past(state_ff == ST_DIV && cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)))
      else $error("gain load without complete division");

endmodule

[rtl/aloa_dp.sv]
// ----------------------------------------------------------------------------
// aloa_dp
// Datapath: configuration registers, offset and gain scaling, loop store
// mixing, extreme tracking and the serial divider for the gain.
// ----------------------------------------------------------------------------
module aloa_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  aloa_pkg::aloa_cmd_type               cmd,
   output aloa_pkg::aloa_stat_type              stat,
   input  logic signed [15:0]                   in_sample,
   output logic signed [15:0]                   out_sample,
   output logic                                 out_clip,
   output logic                                 out_last,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [aloa_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [aloa_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [aloa_pkg::CSR_DATA_W-1:0]      csr_prdata
);
   import aloa_pkg::*;

   // control state (reset)
   logic [15:0]        loop_length_ff, loop_length_in;
   logic [15:0]        clip_limit_ff, clip_limit_in;
   logic [ADDR_W-1:0]  position_ff, position_in;
   logic               overdub_ff, overdub_in;
   logic signed [15:0] imin_ff, imin_in, imax_ff, imax_in;
   logic signed [15:0] smin_ff, smin_in, smax_ff, smax_in;
   logic signed [15:0] offset_ff, offset_in;
   logic [16:0]        gain_ff, gain_in;
   logic               clipping_ff, clipping_in;

   // payload
   logic signed [16:0] diff_ff, diff_in;
   logic [33:0]        prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic [15:0]        range_ff, range_in;
   logic [15:0]        rem_ff, rem_in;
   logic [15:0]        quo_ff, quo_in;
   logic signed [15:0] out_sample_ff, out_sample_in;
   logic               out_last_ff, out_last_in;
   logic               out_clip_ff, out_clip_in;
   logic signed [15:0] stored_ff, stored_in;
   logic               end_ff, end_in;

   // combinational helpers
   logic               csr_wr;
   logic [16:0]        mag;
   logic [17:0]        q;
   logic signed [15:0] scaled;
   logic signed [15:0] stored;
   logic signed [15:0] ram_rd;
   logic signed [15:0] smin_nx, smax_nx;
   logic signed [16:0] span;
   logic signed [16:0] mid_sum, mid_adj;
   logic [CMP_W-1:0]   pos_inc;
   logic               pass_end;
   logic [16:0]        div_t;
   logic               div_ge;

   aloa_ram #(
      .WIDTH (16),
      .DEPTH (LOOP_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (position_ff),
      .wr_data (stored),
      .rd_en   (cmd.accept),
      .rd_addr (position_ff),
      .rd_data (ram_rd)
   );

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[CSR_ADDR_W-1:2])
         REG_LOOP_LENGTH: csr_prdata = CSR_DATA_W'(loop_length_ff);
         REG_CLIP_LIMIT:  csr_prdata = CSR_DATA_W'(clip_limit_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // magnitude times gain, then truncate and saturate with sign restored
   assign mag = diff_ff[16] ? $unsigned(-diff_ff) : $unsigned(diff_ff);
   assign q   = prod_ff[33:16];

   always_comb begin
      if (neg_ff) begin
         scaled = (q >= 18'd32768) ? SAMPLE_MIN : $signed(16'(-q[15:0]));
      end else begin
         scaled = (q > 18'd32767) ? SAMPLE_MAX : $signed(q[15:0]);
      end
   end

   assign stored  = overdub_ff ? 16'(ram_rd + scaled) : scaled;
   assign smax_nx = (stored > smax_ff) ? stored : smax_ff;
   assign smin_nx = (stored < smin_ff) ? stored : smin_ff;
   assign span    = 17'(smax_nx) - 17'(smin_nx);

   // midpoint, truncated toward zero
   assign mid_sum = 17'(imin_ff) + 17'(imax_ff);
   assign mid_adj = mid_sum + (mid_sum[16] ? 17'sd1 : 17'sd0);

   assign pos_inc  = CMP_W'(position_ff) + CMP_W'(1);
   assign pass_end = (loop_length_ff == 16'd0) || (pos_inc >= CMP_W'(loop_length_ff))
                     || (pos_inc == CMP_W'(LOOP_DEPTH));

   assign div_t  = {rem_ff, 1'b0};
   assign div_ge = (div_t >= {1'b0, range_ff});

   assign stat.pass_end = pass_end;
   assign stat.clip     = (range_ff > clip_limit_ff);

   always_comb begin
      loop_length_in = loop_length_ff;
      clip_limit_in  = clip_limit_ff;
      position_in    = position_ff;
      overdub_in     = overdub_ff;
      imin_in        = imin_ff;
      imax_in        = imax_ff;
      smin_in        = smin_ff;
      smax_in        = smax_ff;
      offset_in      = offset_ff;
      gain_in        = gain_ff;
      clipping_in    = clipping_ff;
      diff_in        = diff_ff;
      prod_in        = prod_ff;
      neg_in         = neg_ff;
      range_in       = range_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      out_sample_in  = out_sample_ff;
      out_last_in    = out_last_ff;
      out_clip_in    = out_clip_ff;
      stored_in      = stored_ff;
      end_in         = end_ff;

      if (csr_wr) begin
         unique case (csr_paddr[CSR_ADDR_W-1:2])
            REG_LOOP_LENGTH: loop_length_in = csr_pwdata[15:0];
            REG_CLIP_LIMIT:  clip_limit_in  = csr_pwdata[15:0];
            default: ;
         endcase
      end

      if (cmd.accept) begin
         if (in_sample > imax_ff) imax_in = in_sample;
         if (in_sample < imin_ff) imin_in = in_sample;
         diff_in = 17'(in_sample) - 17'(offset_ff);
      end

      if (cmd.mul) begin
         prod_in = mag * gain_ff;
         neg_in  = diff_ff[16];
      end

      if (cmd.store) begin
         stored_in = stored;
         end_in    = pass_end;
         if (pass_end) begin
            range_in    = span[15:0];
            offset_in   = mid_adj[16:1];
            position_in = '0;
            overdub_in  = 1'b1;
            imin_in     = SAMPLE_MAX;
            imax_in     = SAMPLE_MIN;
            smin_in     = '0;
            smax_in     = '0;
         end else begin
            position_in = pos_inc[ADDR_W-1:0];
            smin_in     = smin_nx;
            smax_in     = smax_nx;
         end
      end

      if (cmd.eval) begin
         clipping_in = stat.clip;
         if (!stat.clip) gain_in = GAIN_UNITY;
         rem_in = clip_limit_ff;
         quo_in = '0;
      end

      if (cmd.div_step) begin
         rem_in = div_ge ? 16'(div_t - {1'b0, range_ff}) : div_t[15:0];
         quo_in = {quo_ff[14:0], div_ge};
      end

      if (cmd.gain_load) begin
         gain_in = {1'b0, quo_ff};
      end

      if (cmd.out_load) begin
         out_sample_in = stored_ff;
         out_last_in   = end_ff;
         out_clip_in   = clipping_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_length_ff <= LOOP_LENGTH_RESET;
         clip_limit_ff  <= CLIP_LIMIT_RESET;
         position_ff    <= '0;
         overdub_ff     <= 1'b0;
         imin_ff        <= SAMPLE_MAX;
         imax_ff        <= SAMPLE_MIN;
         smin_ff        <= '0;
         smax_ff        <= '0;
         offset_ff      <= '0;
         gain_ff        <= GAIN_UNITY;
         clipping_ff    <= 1'b0;
      end else begin
         loop_length_ff <= loop_length_in;
         clip_limit_ff  <= clip_limit_in;
         position_ff    <= position_in;
         overdub_ff     <= overdub_in;
         imin_ff        <= imin_in;
         imax_ff        <= imax_in;
         smin_ff        <= smin_in;
         smax_ff        <= smax_in;
         offset_ff      <= offset_in;
         gain_ff        <= gain_in;
         clipping_ff    <= clipping_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      range_ff      <= range_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
      out_clip_ff   <= out_clip_in;
      stored_ff     <= stored_in;
      end_ff        <= end_in;
   end

   // clip state is sampled at load time, after any pass-end decision
   assign out_sample = out_sample_ff;
   assign out_clip   = out_clip_ff;
   assign out_last   = out_last_ff;

   a_pos_in_store: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(position_ff) < CMP_W'(LOOP_DEPTH))
      else $error("loop position outside store");

   a_gain_max: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_UNITY)
      else $error("gain above unity");

   a_stored_order: assert property (@(posedge clock) disable iff (reset)
      smin_ff <= smax_ff)
      else $error("stored minimum above stored maximum");

   a_unity_no_clip: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && !stat.clip) |=> (gain_ff == GAIN_UNITY && !clipping_ff))
      else $error("gain not restored after unclipped pass");

endmodule

[rtl/audio_loop_overdub_autogain_core.sv]
// ----------------------------------------------------------------------------
// audio_loop_overdub_autogain_core
// Loop recorder with overdub and automatic gain reduction, stream in/out.
// ----------------------------------------------------------------------------
// Each input transfer carries one signed 16-bit sample and produces exactly one
// result transfer carrying the stored loop sample, the clip state and a
// pass-end marker on tlast. A sample goes through capture, multiply, store and
// output load, in that order. The sample that ends a pass also goes through
// the range check before its output load, and when the range exceeds the clip
// limit through the 16-step serial divider that forms the new gain. The input
// is not ready while a sample is in flight; a result held by back-pressure
// stalls the next sample only at its output load. The loop store is not
// cleared: the first pass writes it before later passes read it.
// ----------------------------------------------------------------------------
module audio_loop_overdub_autogain_core (
   input  logic                                clock,
   input  logic                                reset,
   // stream input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // [15:0] in_sample
   // stream output
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,   // [15:0] out_sample
   output logic                                rsp_tuser,   // [0] clip_flag
   output logic                                rsp_tlast,   // pass_end
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [aloa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [aloa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [aloa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import aloa_pkg::*;

   aloa_cmd_type       cmd;
   aloa_stat_type      stat;
   logic signed [15:0] out_sample;

   assign csr_pready = 1'b1;
   assign rsp_tdata  = out_sample;

   aloa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   aloa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_sample   ($signed(req_tdata)),
      .out_sample  (out_sample),
      .out_clip    (rsp_tuser),
      .out_last    (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule

[test/audio_loop_overdub_autogain_core_tb.sv]
// ----------------------------------------------------------------------------
// audio_loop_overdub_autogain_core_tb
// Self-checking bench for the loop recorder with overdub and auto gain.
// ----------------------------------------------------------------------------
// A behavioral loop recorder runs beside the core. Every accepted sample is
// mixed into that recorder to form the expected stored sample, clip state and
// pass-end marker, and each result transfer is compared with the oldest
// expectation. The run records a first pass of FIRST_PASS_LEN entries and
// keeps every later pass inside that recorded region, then covers the length
// and clip-limit corner cases, random traffic under three idle mixes, and a
// long output hold.
// ----------------------------------------------------------------------------
module audio_loop_overdub_autogain_core_tb;
   import aloa_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 5000;  // idle cycles
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned DRAIN_CYCLES   = 64;
   localparam int unsigned FIRST_PASS_LEN = 256;

   typedef struct packed {
      logic [15:0] sample;
      logic        clip;
      logic        last;
   } loop_result_type;

   typedef enum {STYLE_FULL, STYLE_NEAR, STYLE_EDGE} sample_style_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [15:0]             req_tdata   = '0;   // [15:0] in_sample
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [15:0]             rsp_tdata;          // [15:0] out_sample
   logic                    rsp_tuser;          // [0] clip_flag
   logic                    rsp_tlast;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   audio_loop_overdub_autogain_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---- recorder state mirrored by the bench ----
   logic [15:0]        cfg_length     = LOOP_LENGTH_RESET;
   logic [15:0]        cfg_clip_limit = CLIP_LIMIT_RESET;
   logic signed [15:0] loop_image [LOOP_DEPTH];
   int unsigned        rec_pos        = 0;
   int unsigned        fill_top       = 0;   // entries 0..fill_top-1 are recorded
   bit                 overdub        = 1'b0;
   int                 in_lo          = 32767;
   int                 in_hi          = -32768;
   int                 mix_lo         = 0;
   int                 mix_hi         = 0;
   int                 dc_offset      = 0;
   longint unsigned    gain_q16       = 65536;
   bit                 clip_state     = 1'b0;

   loop_result_type expected_results[$];
   loop_result_type next_want;

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   logic        rsp_hold_req = 1'b0;
   logic        rsp_hold_ack = 1'b0;
   int unsigned hold_left    = 0;
   int unsigned stall_cycles = 0;

   int unsigned n_errors    = 0;
   int unsigned n_samples   = 0;
   int unsigned n_results   = 0;
   int unsigned n_passes    = 0;
   int unsigned n_clipped   = 0;

   function automatic void flag_mismatch(input string what, input int unsigned want,
                                         input int unsigned got);
      n_errors++;
      if (n_errors <= 10)
         $display("ERROR %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
   endfunction

   // Mix one sample into the recorder and queue the result it must produce.
   function automatic void predict_sample(input logic signed [15:0] x);
      int unsigned        len, idx, span;
      int                 diff, scaled, mixed;
      longint unsigned    mag, prod;
      logic signed [15:0] wrapped;
      loop_result_type    res;
      len = (cfg_length == 0) ? 1 : cfg_length;
      if (len > LOOP_DEPTH) len = LOOP_DEPTH;
      idx = rec_pos % LOOP_DEPTH;
      if (x > in_hi) in_hi = x;
      if (x < in_lo) in_lo = x;

      // sign-magnitude scaling truncates toward zero
      diff = x - dc_offset;
      mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
      prod = (mag * gain_q16) >> 16;
      if (diff < 0) scaled = (prod >= 32768) ? -32768 : -int'(prod);
      else          scaled = (prod > 32767) ? 32767 : int'(prod);

      if (!overdub) begin
         mixed = scaled;
      end else begin
         wrapped = 16'(loop_image[idx] + scaled);
         mixed   = wrapped;
      end
      loop_image[idx] = 16'(mixed);
      if (!overdub && idx + 1 > fill_top) fill_top = idx + 1;
      if (mixed > mix_hi) mix_hi = mixed;
      if (mixed < mix_lo) mix_lo = mixed;

      res.last = (idx + 1 >= len);
      if (res.last) begin
         span      = mix_hi - mix_lo;
         rec_pos   = 0;
         overdub   = 1'b1;
         dc_offset = (in_lo + in_hi) / 2;
         n_passes++;
         if (span > cfg_clip_limit) begin
            clip_state = 1'b1;
            gain_q16   = (longint'(cfg_clip_limit) << 16) / span;
            n_clipped++;
         end else begin
            clip_state = 1'b0;
            gain_q16   = 65536;
         end
         in_lo  = 32767;
         in_hi  = -32768;
         mix_lo = 0;
         mix_hi = 0;
      end else begin
         rec_pos = idx + 1;
      end
      res.sample = mixed[15:0];
      res.clip   = clip_state;
      expected_results.push_back(res);
   endfunction

   // ---- result side: ready pattern, long holds, checking ----
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_req != rsp_hold_ack) begin
         rsp_hold_ack <= rsp_hold_req;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (expected_results.size() == 0) begin
            flag_mismatch("result transfer with nothing pending", 0, rsp_tdata);
         end else begin
            next_want = expected_results.pop_front();
            if (rsp_tdata !== next_want.sample)
               flag_mismatch("out_sample", next_want.sample, rsp_tdata);
            if (rsp_tuser !== next_want.clip)
               flag_mismatch("clip_flag", next_want.clip, rsp_tuser);
            if (rsp_tlast !== next_want.last)
               flag_mismatch("pass_end", next_want.last, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d results pending",
                  WATCHDOG_LIMIT, expected_results.size());
         $display("audio_loop_overdub_autogain_core_tb: FAIL");
         $finish;
      end
   end

   // ---- drivers ----
   task automatic send_sample(input logic signed [15:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_samples++;
      predict_sample(value);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_read(input logic reg_idx, input logic [15:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * reg_idx);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[15:0] !== want) flag_mismatch("register readback", want, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * reg_idx);
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (reg_idx == REG_LOOP_LENGTH) cfg_length = value;
      else cfg_clip_limit = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_read(reg_idx, value);
   endtask

   function automatic logic signed [15:0] pick_sample(input sample_style_type style,
                                                      input int center, input int amp);
      int v;
      case (style)
         STYLE_FULL: return 16'($urandom);
         STYLE_NEAR: begin
            v = center + int'($urandom_range(0, 2 * amp)) - amp;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return 16'(v);
         end
         default: begin
            case ($urandom_range(3))
               0:       return SAMPLE_MAX;
               1:       return SAMPLE_MIN;
               2:       return 16'sd0;
               default: return -16'sd1;
            endcase
         end
      endcase
   endfunction

   function automatic logic [15:0] pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5)  return 16'd0;
      if (r < 8)  return 16'hFFFF;
      if (r < 10) return 16'(LOOP_DEPTH);
      if (r < 13) return 16'($urandom);  // big; bursts stay inside the recorded region
      return 16'($urandom_range(1, 40));
   endfunction

   function automatic logic [15:0] pick_clip_limit();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return 16'd0;
      if (r < 15) return 16'd1;
      if (r < 25) return 16'hFFFF;
      if (r < 75) return 16'($urandom_range(1, 5000));
      return 16'($urandom);
   endfunction

   // ---- tests ----

   // First pass records FIRST_PASS_LEN entries under lengths at or above the
   // store depth, then is closed by a length lowered below the current position.
   task automatic test_first_pass();
      csr_read(REG_LOOP_LENGTH, LOOP_LENGTH_RESET);
      csr_read(REG_CLIP_LIMIT, CLIP_LIMIT_RESET);
      csr_write(REG_LOOP_LENGTH, 16'hFFFF);   // above store depth
      csr_write(REG_CLIP_LIMIT, 16'hFFFF);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(16'sd0);
      send_sample(-16'sd1);
      repeat (FIRST_PASS_LEN - 8) send_sample(16'($urandom));
      drain_results();
      csr_write(REG_LOOP_LENGTH, 16'(LOOP_DEPTH));
      repeat (3) send_sample(16'($urandom));
      drain_results();
      csr_write(REG_LOOP_LENGTH, 16'd5);
      send_sample(16'($urandom));
      drain_results();
   endtask

   task automatic test_special_cases();
      // zero length ends a pass on every sample; zero limit drives gain to 0
      csr_write(REG_LOOP_LENGTH, 16'd0);
      csr_write(REG_CLIP_LIMIT, 16'd0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(16'sd0);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      drain_results();
      csr_write(REG_LOOP_LENGTH, 16'd1);
      csr_write(REG_CLIP_LIMIT, 16'd1);
      send_sample(16'sd1234);
      send_sample(-16'sd4321);
      drain_results();
      // full depth, then lowered below the current position
      csr_write(REG_LOOP_LENGTH, 16'(LOOP_DEPTH));
      csr_write(REG_CLIP_LIMIT, CLIP_LIMIT_RESET);
      repeat (4) send_sample(16'($urandom));
      drain_results();
      csr_write(REG_LOOP_LENGTH, 16'd3);
      send_sample(16'sd100);
      send_sample(-16'sd100);
      drain_results();
      // full-scale swings against the offset saturate the scaled value
      csr_write(REG_LOOP_LENGTH, 16'd2);
      csr_write(REG_CLIP_LIMIT, 16'hFFFF);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      drain_results();
   endtask

   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned      sent, burst, r, room, eff_len;
      sample_style_type style;
      int               center, amp;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 70) csr_write(REG_LOOP_LENGTH, pick_length());
         if ($urandom_range(99) < 50) csr_write(REG_CLIP_LIMIT, pick_clip_limit());
         r = $urandom_range(99);
         style  = (r < 25) ? STYLE_FULL : (r < 85) ? STYLE_NEAR : STYLE_EDGE;
         center = int'($urandom_range(0, 40000)) - 20000;
         case ($urandom_range(3))
            0:       amp = 20;
            1:       amp = 400;
            2:       amp = 1500;
            default: amp = 6000;
         endcase
         burst = $urandom_range(8, 60);
         // a long pass must stop short of the last recorded entry
         eff_len = (cfg_length == 0) ? 1 : cfg_length;
         if (eff_len > LOOP_DEPTH) eff_len = LOOP_DEPTH;
         if (overdub && eff_len > fill_top) begin
            room = fill_top - 1 - rec_pos;
            if (burst > room) burst = room;
         end
         repeat (burst) send_sample(pick_sample(style, center, amp));
         sent += burst;
         drain_results();
      end
   endtask

   task automatic test_output_backpressure();
      csr_write(REG_LOOP_LENGTH, 16'd7);
      csr_write(REG_CLIP_LIMIT, 16'd2000);
      rsp_hold_req <= ~rsp_hold_req;
      repeat (40) send_sample(pick_sample(STYLE_NEAR, 0, 1500));
      drain_results();
      repeat (40) send_sample(pick_sample(STYLE_FULL, 0, 0));
      drain_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 17;
      rsp_idle_pct = 57;
      test_first_pass();
      test_special_cases();
      test_random_traffic(600);

      req_idle_pct = 57;
      rsp_idle_pct = 17;
      test_random_traffic(600);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(500);
      test_output_backpressure();

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d samples and %0d results over %0d loop passes, %0d with gain cut.",
               n_samples, n_results, n_passes, n_clipped);
      $display("Lengths 0..65535 incl. ones above the store, clip limits 0..65535, %s",
               "three idle mixes and a long output hold.");
      if (n_errors == 0 && expected_results.size() == 0) begin
         $display("audio_loop_overdub_autogain_core_tb: PASS");
      end else begin
         $display("%0d mismatches, %0d results still pending", n_errors,
                  expected_results.size());
         $display("audio_loop_overdub_autogain_core_tb: FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/aloa_pkg.sv
rtl/aloa_ram.sv
rtl/aloa_ctrl.sv
rtl/aloa_dp.sv
rtl/audio_loop_overdub_autogain_core.sv
test/audio_loop_overdub_autogain_core_tb.sv
